@@ hdl/mcema_pkg.sv @@
// shared types, constants and codes of the multichannel oversample ema smoother
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mcema_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS   = 12;
  localparam int VALUE_BITS    = 20;
  localparam int FRAC_BITS     = 8;
  localparam int ALPHA_BITS    = 17;
  localparam int ALPHA_FRAC    = 16;
  localparam int INTERVAL_BITS = 16;
  localparam int CHCOUNT_BITS  = 4;
  localparam int OSCOUNT_BITS  = 7;
  localparam int CHANNEL_BITS  = 8;
  localparam int VCHAN_BITS    = 3;
  localparam int CFG_DATA_BITS = 17;
  localparam int CFG_IDX_BITS  = 2;

  // parameter defaults
  localparam int DEF_MAX_CHANNELS   = 8;
  localparam int DEF_MAX_OVERSAMPLE = 64;

  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE  = ALPHA_BITS'(65536);
  localparam logic [VALUE_BITS-1:0] VALUE_MASK = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLES_PER_CHAN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SMOOTHING_ALPHA  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_PERIOD      = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // what the back end has to do with a queued job
  typedef enum logic [1:0] {
    K_NONE   = 2'd0,
    K_UPDATE = 2'd1,
    K_READ   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE  = 3'd0,
    B_EMIT  = 3'd1,
    B_DIV   = 3'd2,
    B_DIFF  = 3'd3,
    B_MUL   = 3'd4,
    B_APPLY = 3'd5
  } back_state_t;

  typedef struct packed {
    op_t                     op;
    logic [SAMPLE_BITS-1:0]  sample;
    logic [CHANNEL_BITS-1:0] channel;
  } req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [VCHAN_BITS-1:0] value_channel;
    logic                  updated;
    logic                  window_open;
    logic                  sample_ignored;
  } rsp_t;

endpackage

@@ hdl/multichannel_oversample_ema_smoother_core.sv @@
// top level of the multichannel oversample ema smoother
// depends on mcema_pkg, mcema_front, mcema_queue, mcema_back
`timescale 1ns / 1ps

// Oversampling averager with a per-channel exponential moving average. Each
// request beat is a tick, a raw sample or a read. A tick advances the update
// counter and opens a measurement window every tick_period ticks; inside
// a window samples_per_chan samples per channel arrive in channel order, their
// sum is divided by the count (rounded) into a Q12.8 average, and the channel's
// smoothed value moves toward it by smoothing_alpha (Q1.16). Every request
// gives exactly one response beat. Ticks, reads, ignored samples and samples
// that do not finish a channel pass the back end's pop and emit states; a
// sample that finishes a channel runs the bit-serial restoring divider after
// the pop, followed by a difference, a multiply and a write-back state. The
// front end keeps accepting while the back end works, up to two queued jobs.
// The smoothed store is held in per-channel registers with valid bits, so it
// reads as zero right after reset with no clearing pass. The user must write
// configuration through cfg_we/cfg_index/cfg_data only while no request is in
// flight; the block itself does not enforce it.
module multichannel_oversample_ema_smoother_core #(
  parameter int MAX_CHANNELS   = mcema_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_OVERSAMPLE = mcema_pkg::DEF_MAX_OVERSAMPLE
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [mcema_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mcema_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // request channel
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  mcema_pkg::req_t                      req,
  // response channel
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output mcema_pkg::rsp_t                      rsp
);
  import mcema_pkg::*;

  localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ECW   = $clog2(MAX_CHANNELS + 1);
  localparam int NW    = $clog2(MAX_OVERSAMPLE + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_OVERSAMPLE);
  // job word: kind, value channel, channel, sum, count, window, ignored
  localparam int EW    = 7 + CW + SUM_W + NW;

  // configuration registers
  logic [CHCOUNT_BITS-1:0]  channel_count;
  logic [OSCOUNT_BITS-1:0]  samples_per_chan;
  logic [ALPHA_BITS-1:0]    smoothing_alpha;
  logic [INTERVAL_BITS-1:0] tick_period;

  // values actually used after clamping
  logic [ECW-1:0]           eff_channels;
  logic [NW-1:0]            eff_oversample;
  logic [ALPHA_BITS-1:0]    eff_alpha;

  logic                     push, pop, q_full, q_valid;
  logic [EW-1:0]            push_data, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count    <= CHCOUNT_BITS'(1);
      samples_per_chan <= OSCOUNT_BITS'(1);
      smoothing_alpha  <= ALPHA_ONE;
      tick_period      <= INTERVAL_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT:    channel_count    <= cfg_data[CHCOUNT_BITS-1:0];
        CFG_SAMPLES_PER_CHAN: samples_per_chan <= cfg_data[OSCOUNT_BITS-1:0];
        CFG_SMOOTHING_ALPHA:  smoothing_alpha  <= cfg_data[ALPHA_BITS-1:0];
        CFG_TICK_PERIOD:      tick_period      <= cfg_data[INTERVAL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero counts act as one, oversized ones saturate to the build limits
  always_comb begin
    if (channel_count == '0) begin
      eff_channels = ECW'(1);
    end else if (int'(channel_count) > MAX_CHANNELS) begin
      eff_channels = ECW'(MAX_CHANNELS);
    end else begin
      eff_channels = ECW'(channel_count);
    end

    if (samples_per_chan == '0) begin
      eff_oversample = NW'(1);
    end else if (int'(samples_per_chan) > MAX_OVERSAMPLE) begin
      eff_oversample = NW'(MAX_OVERSAMPLE);
    end else begin
      eff_oversample = NW'(samples_per_chan);
    end

    // alpha above one saturates to exactly one
    eff_alpha = (smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : smoothing_alpha;
  end

  // front end: window bookkeeping, one beat per cycle while the queue has room
  mcema_front #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .MAX_OVERSAMPLE (MAX_OVERSAMPLE),
    .CW             (CW),
    .ECW            (ECW),
    .NW             (NW),
    .SUM_W          (SUM_W),
    .EW             (EW)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .eff_channels    (eff_channels),
    .eff_oversample  (eff_oversample),
    .tick_period     (tick_period),
    .q_full          (q_full),
    .push            (push),
    .push_data       (push_data)
  );

  // decouples window bookkeeping from the slow divide/multiply path
  mcema_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  // back end: divide, ema update, store, registered response
  mcema_back #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .MAX_OVERSAMPLE (MAX_OVERSAMPLE),
    .CW             (CW),
    .NW             (NW),
    .SUM_W          (SUM_W),
    .EW             (EW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .alpha     (eff_alpha),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ hdl/mcema_front.sv @@
// front end: takes request beats, runs tick counter and window bookkeeping
// depends on mcema_pkg; pushes classified jobs into mcema_queue
`timescale 1ns / 1ps

module mcema_front #(
  parameter int MAX_CHANNELS   = mcema_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_OVERSAMPLE = mcema_pkg::DEF_MAX_OVERSAMPLE,
  parameter int CW             = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int ECW            = $clog2(MAX_CHANNELS + 1),
  parameter int NW             = $clog2(MAX_OVERSAMPLE + 1),
  parameter int SUM_W          = mcema_pkg::SAMPLE_BITS + $clog2(MAX_OVERSAMPLE),
  parameter int EW             = 7 + CW + SUM_W + NW
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_ready,
  input  mcema_pkg::req_t                        req,
  input  logic [ECW-1:0]                         eff_channels,
  input  logic [NW-1:0]                          eff_oversample,
  input  logic [mcema_pkg::INTERVAL_BITS-1:0]    tick_period,
  input  logic                                   q_full,
  output logic                                   push,
  output logic [EW-1:0]                          push_data
);
  import mcema_pkg::*;

  typedef struct packed {
    kind_t                 kind;
    logic [VCHAN_BITS-1:0] vchan;
    logic [CW-1:0]         ch;
    logic [SUM_W-1:0]      sum;
    logic [NW-1:0]         n;
    logic                  win;
    logic                  ign;
  } entry_t;

  logic [INTERVAL_BITS-1:0] tick_count, tick_count_next, tick_inc;
  logic                     window_active, window_active_next;
  logic [CW-1:0]            current_channel, current_channel_next;
  logic [NW-1:0]            samples_taken, samples_taken_next, taken_inc;
  logic [SUM_W-1:0]         sample_sum, sample_sum_next, sum_add;
  logic [ECW-1:0]           cur_inc;
  logic                     accept;
  entry_t                   ent;

  assign req_ready = !q_full;
  assign accept    = req_valid && req_ready;
  assign push      = accept;
  assign push_data = ent;

  assign tick_inc  = tick_count + INTERVAL_BITS'(1);
  assign sum_add   = sample_sum + SUM_W'(req.sample);
  assign taken_inc = samples_taken + NW'(1);
  assign cur_inc   = ECW'(current_channel) + ECW'(1);

  always_comb begin
    tick_count_next      = tick_count;
    window_active_next   = window_active;
    current_channel_next = current_channel;
    samples_taken_next   = samples_taken;
    sample_sum_next      = sample_sum;
    ent                  = '0;
    ent.kind             = K_NONE;
    if (accept) begin
      unique case (req.op)
        OP_TICK: begin
          if (tick_inc >= tick_period) begin
            // interval reached: (re)open the window from channel zero
            tick_count_next      = '0;
            window_active_next   = 1'b1;
            current_channel_next = '0;
            samples_taken_next   = '0;
            sample_sum_next      = '0;
          end else begin
            tick_count_next = tick_inc;
          end
        end
        OP_SAMPLE: begin
          if (!window_active) begin
            ent.ign = 1'b1;
          end else if (taken_inc >= eff_oversample) begin
            ent.kind           = K_UPDATE;
            ent.ch             = current_channel;
            ent.vchan          = VCHAN_BITS'(current_channel);
            ent.sum            = sum_add;
            ent.n              = eff_oversample;
            sample_sum_next    = '0;
            samples_taken_next = '0;
            if (cur_inc >= eff_channels) begin
              window_active_next   = 1'b0;
              current_channel_next = '0;
            end else begin
              current_channel_next = CW'(cur_inc);
            end
          end else begin
            sample_sum_next    = sum_add;
            samples_taken_next = taken_inc;
          end
        end
        OP_READ: begin
          if (req.channel < CHANNEL_BITS'(eff_channels)) begin
            ent.kind  = K_READ;
            ent.ch    = CW'(req.channel);
            ent.vchan = req.channel[VCHAN_BITS-1:0];
          end
        end
        OP_NONE: begin
        end
      endcase
    end
    ent.win = window_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      window_active   <= 1'b0;
      current_channel <= '0;
      samples_taken   <= '0;
      sample_sum      <= '0;
    end else begin
      tick_count      <= tick_count_next;
      window_active   <= window_active_next;
      current_channel <= current_channel_next;
      samples_taken   <= samples_taken_next;
      sample_sum      <= sample_sum_next;
    end
  end

endmodule

@@ hdl/mcema_queue.sv @@
// two-entry job queue between front and back end
// depends on mcema_pkg only for house style; payload is an opaque vector
`timescale 1ns / 1ps

module mcema_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output logic [WIDTH-1:0] head
);
  import mcema_pkg::*;

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/mcema_back.sv @@
// back end: serial divider, ema multiply, smoothed value store, result register
// depends on mcema_pkg; pops jobs from mcema_queue
`timescale 1ns / 1ps

module mcema_back #(
  parameter int MAX_CHANNELS   = mcema_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_OVERSAMPLE = mcema_pkg::DEF_MAX_OVERSAMPLE,
  parameter int CW             = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int NW             = $clog2(MAX_OVERSAMPLE + 1),
  parameter int SUM_W          = mcema_pkg::SAMPLE_BITS + $clog2(MAX_OVERSAMPLE),
  parameter int EW             = 7 + CW + SUM_W + NW
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  logic [EW-1:0]                      head,
  output logic                               pop,
  input  logic [mcema_pkg::ALPHA_BITS-1:0]   alpha,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output mcema_pkg::rsp_t                    rsp
);
  import mcema_pkg::*;

  typedef struct packed {
    kind_t                 kind;
    logic [VCHAN_BITS-1:0] vchan;
    logic [CW-1:0]         ch;
    logic [SUM_W-1:0]      sum;
    logic [NW-1:0]         n;
    logic                  win;
    logic                  ign;
  } entry_t;

  localparam int DW     = SUM_W + FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(DW + 1);
  localparam int PROD_W = VALUE_BITS + ALPHA_BITS;
  localparam int Q_W    = PROD_W - ALPHA_FRAC;

  back_state_t state, state_next;

  entry_t                 hd, job;
  logic [VALUE_BITS-1:0]  store [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] store_valid;
  logic [VALUE_BITS-1:0]  rd_data;

  logic [DW-1:0]          dq;
  logic [NW-1:0]          rem;
  logic [CNT_W-1:0]       cnt;
  logic [NW:0]            trial, trial_sub;
  logic                   ge;

  logic [VALUE_BITS-1:0]  avg, diff;
  logic                   neg;
  logic [PROD_W-1:0]      prod, rounded;
  logic [Q_W-1:0]         q;
  logic [VALUE_BITS-1:0]  new_val;

  logic                   out_free, out_load, store_we;
  rsp_t                   rsp_next;

  assign hd       = head;
  assign out_free = !rsp_valid || rsp_ready;

  // one restoring division step per cycle
  assign trial     = {rem, dq[DW-1]};
  assign trial_sub = trial - {1'b0, job.n};
  assign ge        = (trial >= {1'b0, job.n});

  assign avg     = (dq > DW'(VALUE_MASK)) ? VALUE_MASK : dq[VALUE_BITS-1:0];
  assign rounded = prod + PROD_W'(1 << (ALPHA_FRAC - 1));
  assign q       = rounded[PROD_W-1:ALPHA_FRAC];
  assign new_val = neg ? (rd_data - q[VALUE_BITS-1:0]) : (rd_data + q[VALUE_BITS-1:0]);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = (hd.kind == K_UPDATE) ? B_DIV : B_EMIT;
        end
      end
      B_EMIT:  if (out_free) state_next = B_IDLE;
      B_DIV:   if (cnt == CNT_W'(1)) state_next = B_DIFF;
      B_DIFF:  state_next = B_MUL;
      B_MUL:   state_next = B_APPLY;
      B_APPLY: if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    store_we = 1'b0;
    rsp_next = '0;
    rsp_next.window_open    = job.win;
    rsp_next.sample_ignored = job.ign;
    unique case (state)
      B_IDLE: pop = q_valid;
      B_EMIT: begin
        out_load = out_free;
        if (job.kind == K_READ) begin
          rsp_next.value         = rd_data;
          rsp_next.value_channel = job.vchan;
        end
      end
      B_APPLY: begin
        out_load               = out_free;
        store_we               = out_free;
        rsp_next.value         = new_val;
        rsp_next.value_channel = job.vchan;
        rsp_next.updated       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      job     <= hd;
      rd_data <= store_valid[hd.ch] ? store[hd.ch] : '0;
      dq      <= DW'({hd.sum, FRAC_BITS'(0)}) + DW'(hd.n >> 1);
      rem     <= '0;
      cnt     <= CNT_W'(DW);
    end
    if (state == B_DIV) begin
      rem <= ge ? NW'(trial_sub) : NW'(trial);
      dq  <= {dq[DW-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
    if (state == B_DIFF) begin
      neg  <= (avg < rd_data);
      diff <= (avg >= rd_data) ? (avg - rd_data) : (rd_data - avg);
    end
    if (state == B_MUL) begin
      prod <= PROD_W'(diff) * PROD_W'(alpha);
    end
  end

  // smoothed value store; entries never written read as zero
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[job.ch] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_valid <= '0;
    end else if (store_we) begin
      store_valid[job.ch] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= rsp_next;
    end
  end

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_DIFF |-> rem < job.n)
    else $error("divider remainder not below divisor");

  a_div_job: assert property (@(posedge clk) disable iff (rst)
    state == B_DIV |-> (job.kind == K_UPDATE) && (job.n != '0))
    else $error("divider running without an update job or with zero count");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.updated && rsp.sample_ignored))
    else $error("result both updated and ignored");

endmodule

@@ bench/mcema_smoother_check.sv @@
// checker for the multichannel oversample ema smoother: predicts every response beat
// from the accepted request beats and register writes, then compares field by field
// depends on mcema_pkg only
`timescale 1ns / 1ps

module mcema_smoother_check (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mcema_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mcema_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                                req_valid,
  input  logic                                req_ready,
  input  mcema_pkg::req_t                     req,
  input  logic                                rsp_valid,
  input  logic                                rsp_ready,
  input  mcema_pkg::rsp_t                     rsp,
  output int                                  errors,
  output int                                  pending
);
  import mcema_pkg::*;

  // register copies
  logic [CHCOUNT_BITS-1:0]  chan_count;
  logic [OSCOUNT_BITS-1:0]  over_count;
  logic [ALPHA_BITS-1:0]    alpha;
  logic [INTERVAL_BITS-1:0] interval;

  // block state
  logic [INTERVAL_BITS-1:0] ticks;
  logic                     in_window;
  logic [VCHAN_BITS-1:0]    cur_chan;
  logic [6:0]               taken;
  logic [17:0]              acc;
  logic [VALUE_BITS-1:0]    smoothed [8];

  rsp_t due_rsp [$];
  rsp_t want;
  int   fail_n;

  assign errors = fail_n;

  // old + alpha*(avg-old), product rounded half away from zero
  function automatic logic [VALUE_BITS-1:0] ema_blend(logic [VALUE_BITS-1:0] old,
                                                      logic [VALUE_BITS-1:0] avg);
    logic [63:0] w;
    logic [63:0] q;
    w = (alpha > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha);
    if (avg >= old) begin
      q = (64'(avg - old) * w + 64'd32768) >> ALPHA_FRAC;
      return old + q[VALUE_BITS-1:0];
    end
    q = (64'(old - avg) * w + 64'd32768) >> ALPHA_FRAC;
    return old - q[VALUE_BITS-1:0];
  endfunction

  function automatic rsp_t smoother_predict(req_t r);
    rsp_t        o;
    int unsigned nch;
    int unsigned nos;
    logic [63:0] avg;
    logic [INTERVAL_BITS-1:0] nxt;
    o = '0;
    nch = (chan_count == 0) ? 1 : (chan_count > 8 ? 8 : chan_count);
    nos = (over_count == 0) ? 1 : (over_count > 64 ? 64 : over_count);
    case (r.op)
      OP_TICK: begin
        nxt = ticks + 16'd1;
        if (nxt >= interval) begin
          ticks = '0;
          in_window = 1'b1;
          cur_chan = '0;
          taken = '0;
          acc = '0;
        end else begin
          ticks = nxt;
        end
      end
      OP_SAMPLE: begin
        if (!in_window) begin
          o.sample_ignored = 1'b1;
        end else begin
          acc = acc + 18'(r.sample);
          taken = taken + 7'd1;
          if (taken >= nos) begin
            avg = ((64'(acc) << FRAC_BITS) + 64'(nos / 2)) / 64'(nos);
            if (avg > 64'(VALUE_MASK)) avg = 64'(VALUE_MASK);
            smoothed[cur_chan] = ema_blend(smoothed[cur_chan], avg[VALUE_BITS-1:0]);
            o.value = smoothed[cur_chan];
            o.value_channel = cur_chan;
            o.updated = 1'b1;
            acc = '0;
            taken = '0;
            if (int'(cur_chan) + 1 >= nch) begin
              in_window = 1'b0;
              cur_chan = '0;
            end else begin
              cur_chan = cur_chan + 3'd1;
            end
          end
        end
      end
      OP_READ: begin
        if (r.channel < nch) begin
          o.value = smoothed[r.channel[2:0]];
          o.value_channel = r.channel[2:0];
        end
      end
      default: ;
    endcase
    o.window_open = in_window;
    return o;
  endfunction

  task automatic flag_field(input string field, input int unsigned exp_v,
                            input int unsigned got_v);
    $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, exp_v, got_v);
    fail_n++;
  endtask

  initial fail_n = 0;

  always @(posedge clk) begin
    if (rst) begin
      chan_count = 4'd1;
      over_count = 7'd1;
      alpha = ALPHA_ONE;
      interval = 16'd1;
      ticks = '0;
      in_window = 1'b0;
      cur_chan = '0;
      taken = '0;
      acc = '0;
      for (int i = 0; i < 8; i++) smoothed[i] = '0;
      due_rsp.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHANNEL_COUNT:    chan_count = cfg_data[CHCOUNT_BITS-1:0];
          CFG_SAMPLES_PER_CHAN: over_count = cfg_data[OSCOUNT_BITS-1:0];
          CFG_SMOOTHING_ALPHA:  alpha = cfg_data[ALPHA_BITS-1:0];
          CFG_TICK_PERIOD:      interval = cfg_data[INTERVAL_BITS-1:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) due_rsp.push_back(smoother_predict(req));
      if (rsp_valid && rsp_ready) begin
        if (due_rsp.size() == 0) begin
          $display("%0t ns: unexpected response beat, expected none actual %h", $time, rsp);
          fail_n++;
        end else begin
          want = due_rsp.pop_front();
          if (rsp.value !== want.value) flag_field("value", want.value, rsp.value);
          if (rsp.value_channel !== want.value_channel)
            flag_field("value_channel", want.value_channel, rsp.value_channel);
          if (rsp.updated !== want.updated) flag_field("updated", want.updated, rsp.updated);
          if (rsp.window_open !== want.window_open)
            flag_field("window_open", want.window_open, rsp.window_open);
          if (rsp.sample_ignored !== want.sample_ignored)
            flag_field("sample_ignored", want.sample_ignored, rsp.sample_ignored);
        end
      end
    end
    pending <= due_rsp.size();
  end

endmodule

@@ bench/multichannel_oversample_ema_smoother_core_test.sv @@
// top of the smoother testbench: clock, reset, request and register stimulus, verdict
// depends on mcema_pkg, mcema_smoother_check and the block under test
`timescale 1ns / 1ps

module multichannel_oversample_ema_smoother_core_test;
  import mcema_pkg::*;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_CHANNEL_COUNT;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     req_valid = 1'b0;
  logic                     req_ready;
  req_t                     req = '0;
  logic                     rsp_valid;
  logic                     rsp_ready = 1'b0;
  rsp_t                     rsp;

  int errors;
  int pending;

  // idling knobs: percent of cycles the sender sits idle / the receiver stalls
  int idle_pct = 0;
  int stall_pct = 0;

  // what the stimulus knows about the current settings, for shaping windows
  int n_chan = 1;
  int n_over = 1;
  int interval_now = 1;
  int beats_sent = 0;

  multichannel_oversample_ema_smoother_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  mcema_smoother_check check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver: one ready decision per edge
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  // hard stop in case the block hangs
  initial begin
    #12_000_000;
    $display("simulation failed");
    $finish;
  end

  // one request beat; valid stays up across back-to-back beats, and only
  // drops while the sender takes an idle gap
  task automatic send_beat(input op_t op, input logic [SAMPLE_BITS-1:0] smp,
                           input logic [CHANNEL_BITS-1:0] ch);
    req_t r;
    r.op = op;
    r.sample = smp;
    r.channel = ch;
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    beats_sent++;
  endtask

  // every beat gets exactly one response, so an empty expectation store
  // means the block has nothing left in flight
  task automatic drain;
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // writes all four registers on consecutive edges, write enable held high
  task automatic set_config(input int cc, input int os, input int al, input int iv);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHANNEL_COUNT;
    cfg_data <= CFG_DATA_BITS'(cc);
    @(posedge clk);
    cfg_index <= CFG_SAMPLES_PER_CHAN;
    cfg_data <= CFG_DATA_BITS'(os);
    @(posedge clk);
    cfg_index <= CFG_SMOOTHING_ALPHA;
    cfg_data <= CFG_DATA_BITS'(al);
    @(posedge clk);
    cfg_index <= CFG_TICK_PERIOD;
    cfg_data <= CFG_DATA_BITS'(iv);
    @(posedge clk);
    cfg_we <= 1'b0;
    // effective values as the block clamps them
    n_chan = (cc % 16 == 0) ? 1 : (cc % 16 > 8 ? 8 : cc % 16);
    n_over = (os % 128 == 0) ? 1 : (os % 128 > 64 ? 64 : os % 128);
    interval_now = iv % 65536;
  endtask

  // raw codes lean on both rails now and then
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int unsigned k;
    k = $urandom_range(9);
    if (k == 0) return '0;
    if (k == 1) return '1;
    return SAMPLE_BITS'($urandom);
  endfunction

  // reads mostly hit real channels, sometimes the whole index range
  function automatic logic [CHANNEL_BITS-1:0] pick_channel();
    if ($urandom_range(4) != 0) return CHANNEL_BITS'($urandom_range(7));
    return CHANNEL_BITS'($urandom);
  endfunction

  // well-formed update windows with random content: up to six ticks toward opening a
  // window, then one channel's worth of samples after another; a few noise
  // beats land in the middle (reads, unused op, stray ticks that restart the
  // window) and some windows are cut short
  task automatic play_windows(input int budget);
    int stop_at;
    int lead;
    int span;
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) begin
      lead = (interval_now <= 1) ? 1 : (interval_now > 6 ? 6 : interval_now);
      repeat (lead) send_beat(OP_TICK, SAMPLE_BITS'($urandom), CHANNEL_BITS'($urandom));
      span = n_chan * n_over;
      if ($urandom_range(9) == 0) span = $urandom_range(span);
      for (int i = 0; i < span; i++) begin
        if ($urandom_range(99) < 6)
          send_beat(op_t'($urandom_range(3)), pick_sample(), pick_channel());
        else
          send_beat(OP_SAMPLE, pick_sample(), CHANNEL_BITS'($urandom));
      end
      repeat ($urandom_range(3)) send_beat(OP_READ, SAMPLE_BITS'($urandom), pick_channel());
    end
  endtask

  task automatic idle_mode(input int m);
    case (m)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 86; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 86; end
      default: begin idle_pct = 11; stall_pct <= 11; end
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    idle_mode(3);

    // reset settings: one channel, one sample, alpha of one, every tick
    send_beat(OP_SAMPLE, 12'hfff, 8'h00);     // no window yet, ignored
    send_beat(OP_NONE, 12'hfff, 8'hff);       // unused op, no effect
    send_beat(OP_READ, 12'h000, 8'h00);       // cleared store reads zero
    send_beat(OP_READ, 12'h000, 8'hff);       // far out of range
    send_beat(OP_READ, 12'h000, 8'h01);       // just past the channel count
    send_beat(OP_TICK, 12'h000, 8'h00);       // opens a window
    send_beat(OP_SAMPLE, 12'hfff, 8'h00);     // full scale, rising step
    send_beat(OP_READ, 12'h000, 8'h00);
    send_beat(OP_TICK, 12'h000, 8'h00);
    send_beat(OP_TICK, 12'h000, 8'h00);       // interval hit with window open
    send_beat(OP_SAMPLE, 12'h000, 8'h00);     // falling step to zero
    send_beat(OP_SAMPLE, 12'h011, 8'h00);     // window already closed
    drain();

    // four channels, half weight, window every second tick
    set_config(4, 1, 32768, 2);
    send_beat(OP_TICK, 12'h000, 8'h00);
    send_beat(OP_TICK, 12'h000, 8'h00);
    send_beat(OP_SAMPLE, 12'hfff, 8'h00);
    send_beat(OP_SAMPLE, 12'h800, 8'h00);
    drain();

    // channel count dropped below the channel in progress: the window
    // closes once that channel finishes
    set_config(2, 1, 32768, 2);
    send_beat(OP_SAMPLE, 12'h064, 8'h00);
    send_beat(OP_READ, 12'h000, 8'h02);
    send_beat(OP_READ, 12'h000, 8'h01);
    drain();

    // alpha above one saturates; zero interval opens on every tick
    set_config(3, 2, 131071, 0);
    send_beat(OP_TICK, 12'h000, 8'h00);
    send_beat(OP_SAMPLE, 12'hfff, 8'h00);
    send_beat(OP_SAMPLE, 12'hffe, 8'h00);     // odd sum, rounded average
    send_beat(OP_TICK, 12'h000, 8'h00);       // restart from channel zero
    send_beat(OP_SAMPLE, 12'h001, 8'h00);
    send_beat(OP_READ, 12'h000, 8'h00);
    drain();

    // random phases: each one sets the registers while idle, then cycles
    // through the idling patterns
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: set_config(1, 1, 65536, 1);
        1: set_config(15, 2, $urandom_range(65536), 0);      // clamps to eight
        2: set_config(8, 0, 131071, 2);                      // zero oversample
        3: set_config(0, 3, 0, 3);                           // zero channels, frozen ema
        4: set_config(2, 127, $urandom_range(131071), 1);    // clamps to 64
        5: set_config(3, 64, $urandom_range(1, 65535), 1);
        6: set_config($urandom_range(1, 8), $urandom_range(1, 5),
                      $urandom_range(65536), $urandom_range(4));
        7: set_config(5, 1, 1, 65535);                       // windows never open
        default: set_config($urandom_range(1, 8), $urandom_range(1, 3),
                            $urandom_range(131071), $urandom_range(2));
      endcase
      idle_mode(p % 4);
      play_windows(p == 7 ? 30 : 110);
      drain();
    end

    // settle: let any stray beat from the back end show up
    stall_pct <= 0;
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
